[rtl/mchw_pkg.sv]
`default_nettype none

package mchw_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned TIMER_W      = 8;
  localparam int unsigned TICK_W       = 6;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam logic [TICK_W-1:0]  TICK_RESET    = TICK_W'(5);
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(180);

  // Channel order: bit 0 remote BMC, bit 1 local SCC, bit 2 remote SCC, bit 3 BIC.
  localparam logic [NUM_CHANNELS-1:0] SEL_UNKNOWN = 4'b1010;
  localparam logic [NUM_CHANNELS-1:0] SEL_TYPE5   = 4'b1011;
  localparam logic [NUM_CHANNELS-1:0] SEL_TYPE7   = 4'b1110;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_TYPE5   = 2'd1,
    MODE_TYPE7   = 2'd2
  } chassis_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHASSIS_MODE = 2'd0,
    REG_TICK_SECONDS = 2'd1,
    REG_TIMEOUT_SECS = 2'd2
  } cfg_reg_e;

  // The undefined mode code falls back to the unknown chassis selection.
  function automatic logic [NUM_CHANNELS-1:0] checked_channels(input logic [MODE_W-1:0] mode);
    logic [NUM_CHANNELS-1:0] sel;
    case (mode)
      MODE_TYPE5: sel = SEL_TYPE5;
      MODE_TYPE7: sel = SEL_TYPE7;
      default:    sel = SEL_UNKNOWN;
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

[rtl/multi_channel_heartbeat_watchdog.sv]
// Each result is registered in the output register when its input transfer takes place.
// Throughput: one poll tick per cycle unless the result side stalls; the per-channel
// timer update is combinational between the input port and the result register.
// Reset (rst_ni low, asynchronous): timers and statuses cleared, external flag normal,
// chassis mode unknown, tick length 5 and timeout 180; no result is pending.
`default_nettype none

module multi_channel_heartbeat_watchdog (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic [mchw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mchw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Poll tick input channel.
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [mchw_pkg::NUM_CHANNELS-1:0]   beat_ok_i,
  input  wire logic                                ext_abnormal_i,
  // Result channel.
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [mchw_pkg::NUM_CHANNELS-1:0]        assert_mask_o,
  output logic [mchw_pkg::NUM_CHANNELS-1:0]        deassert_mask_o,
  output logic [mchw_pkg::NUM_CHANNELS-1:0]        abnormal_mask_o,
  output logic                                     raise_ext_flag_o
);

  localparam int unsigned NCH  = mchw_pkg::NUM_CHANNELS;
  localparam int unsigned TW   = mchw_pkg::TIMER_W;

  // Configuration registers.
  logic [mchw_pkg::MODE_W-1:0] chassis_mode_q;
  logic [mchw_pkg::TICK_W-1:0] tick_q;
  logic [TW-1:0]               timeout_q;

  // Watchdog state.
  logic [TW-1:0]  timer_q [NCH];
  logic [TW-1:0]  timer_d [NCH];
  logic [NCH-1:0] abn_q, abn_d;
  logic           last_ext_q;

  // Result register.
  logic           out_valid_q;
  logic [NCH-1:0] assert_q, assert_d;
  logic [NCH-1:0] deassert_q, deassert_d;
  logic [NCH-1:0] abn_out_q;

  logic           in_xfer;
  logic           ext_falling;
  logic [NCH-1:0] sel;

  // The result register frees itself when its transfer completes, so a new tick is
  // taken in the same cycle that the previous result leaves.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign sel         = mchw_pkg::checked_channels(chassis_mode_q);
  assign ext_falling = last_ext_q && !ext_abnormal_i;

  // Per-channel update. A timer that would pass the timeout saturates at it and marks
  // the channel abnormal; a timer equal to the timeout is still normal. The sum is one
  // bit wider than the timer so that it never wraps. Unchecked channels hold.
  always_comb begin
    logic [TW:0]   sum;
    logic          now;
    logic [TW-1:0] t_new;
    assert_d   = '0;
    deassert_d = '0;
    abn_d      = abn_q;
    for (int c = 0; c < NCH; c++) begin
      sum   = '0;
      now   = 1'b0;
      t_new = timer_q[c];
      if (sel[c]) begin
        if (beat_ok_i[c]) begin
          sum = '0;
        end else begin
          sum = {1'b0, timer_q[c]} + (TW+1)'(tick_q);
        end
        if (sum > {1'b0, timeout_q}) begin
          t_new = timeout_q;
          now   = 1'b1;
        end else begin
          t_new = sum[TW-1:0];
          now   = 1'b0;
        end
        assert_d[c]   = now && !abn_q[c];
        deassert_d[c] = !now && abn_q[c];
        abn_d[c]      = now;
      end
      // When the external flag returns to normal all timers restart from zero, but the
      // statuses computed on this tick are kept.
      timer_d[c] = ext_falling ? '0 : t_new;
    end
  end

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chassis_mode_q <= mchw_pkg::MODE_UNKNOWN;
      tick_q         <= mchw_pkg::TICK_RESET;
      timeout_q      <= mchw_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mchw_pkg::REG_CHASSIS_MODE: chassis_mode_q <= cfg_wdata_i[mchw_pkg::MODE_W-1:0];
        mchw_pkg::REG_TICK_SECONDS: tick_q         <= cfg_wdata_i[mchw_pkg::TICK_W-1:0];
        mchw_pkg::REG_TIMEOUT_SECS: timeout_q      <= cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // Watchdog state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) begin
        timer_q[c] <= '0;
      end
      abn_q      <= '0;
      last_ext_q <= 1'b0;
    end else if (in_xfer) begin
      timer_q    <= timer_d;
      abn_q      <= abn_d;
      last_ext_q <= ext_abnormal_i;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      assert_q   <= assert_d;
      deassert_q <= deassert_d;
      abn_out_q  <= abn_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign assert_mask_o    = assert_q;
  assign deassert_mask_o  = deassert_q;
  assign abnormal_mask_o  = abn_out_q;
  assign raise_ext_flag_o = |assert_q;

  // A channel cannot turn abnormal and normal on the same tick.
  a_assert_deassert_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((assert_q & deassert_q) == '0))
    else $error("channel both asserted and deasserted");

  // A newly abnormal channel shows as abnormal in the reported status.
  a_assert_in_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((assert_q & ~abn_out_q) == '0))
    else $error("asserted channel missing from status");

  // A newly normal channel no longer shows as abnormal.
  a_deassert_not_in_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((deassert_q & abn_out_q) == '0))
    else $error("deasserted channel still abnormal in status");

  // The reported status follows the internal status after every accepted tick.
  a_status_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (abn_out_q == abn_q))
    else $error("reported status differs from channel state");

endmodule

`default_nettype wire

[test/mchw_checker.sv]
`timescale 1ns / 1ps

module mchw_checker
  import mchw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [NUM_CHANNELS-1:0] beat_ok_i,
  input  logic                    ext_abnormal_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [NUM_CHANNELS-1:0] assert_mask_i,
  input  logic [NUM_CHANNELS-1:0] deassert_mask_i,
  input  logic [NUM_CHANNELS-1:0] abnormal_mask_i,
  input  logic                    raise_ext_flag_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] assert_mask;
    logic [NUM_CHANNELS-1:0] deassert_mask;
    logic [NUM_CHANNELS-1:0] abnormal_mask;
    logic                    raise;
  } verdict_t;

  logic [MODE_W-1:0]   mode_q;
  logic [TICK_W-1:0]   tick_q;
  logic [TIMER_W-1:0]  limit_q;
  logic [TIMER_W-1:0]  miss_timer [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] flagged;
  logic                last_ext;
  verdict_t            verdict_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Works out the result of one poll tick and advances the channel state.
  task automatic poll_tick(input logic [NUM_CHANNELS-1:0] beats, input logic ext,
                           output verdict_t v);
    logic [NUM_CHANNELS-1:0] watched;
    logic [TIMER_W:0]        sum;
    logic                    now;
    v = '0;
    case (mode_q)
      MODE_TYPE5: watched = SEL_TYPE5;
      MODE_TYPE7: watched = SEL_TYPE7;
      default:    watched = SEL_UNKNOWN;
    endcase
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (watched[c]) begin
        sum = beats[c] ? '0 : {1'b0, miss_timer[c]} + (TIMER_W+1)'(tick_q);
        now = sum > {1'b0, limit_q};
        if (now) sum = {1'b0, limit_q};
        miss_timer[c] = sum[TIMER_W-1:0];
        if (now && !flagged[c]) v.assert_mask[c] = 1'b1;
        else if (!now && flagged[c]) v.deassert_mask[c] = 1'b1;
        flagged[c] = now;
      end
    end
    v.abnormal_mask = flagged;
    v.raise = |v.assert_mask;
    // A falling external flag clears the timers but leaves the statuses alone.
    if (last_ext && !ext) begin
      for (int c = 0; c < NUM_CHANNELS; c++) miss_timer[c] = '0;
    end
    last_ext = ext;
  endtask

  task automatic report(input bit orphan, input verdict_t want, input verdict_t seen);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      if (orphan)
        $display("%0t: result with no tick outstanding: assert %h deassert %h abnormal %h raise %b",
                 $realtime, seen.assert_mask, seen.deassert_mask, seen.abnormal_mask, seen.raise);
      else
        $display("%0t: mismatch: expected assert %h deassert %h abnormal %h raise %b, got assert %h deassert %h abnormal %h raise %b",
                 $realtime, want.assert_mask, want.deassert_mask, want.abnormal_mask, want.raise,
                 seen.assert_mask, seen.deassert_mask, seen.abnormal_mask, seen.raise);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    verdict_t seen;
    if (!rst_ni) begin
      mode_q   = MODE_UNKNOWN;
      tick_q   = TICK_RESET;
      limit_q  = TIMEOUT_RESET;
      flagged  = '0;
      last_ext = 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) miss_timer[c] = '0;
      verdict_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CHASSIS_MODE: mode_q  = cfg_wdata_i[MODE_W-1:0];
          REG_TICK_SECONDS: tick_q  = cfg_wdata_i[TICK_W-1:0];
          REG_TIMEOUT_SECS: limit_q = cfg_wdata_i[TIMER_W-1:0];
          default: ;
        endcase
      end
      // The result transfer of this edge belongs to an earlier tick, so it is
      // retired before the tick of this edge is predicted.
      if (out_valid_i && out_ready_i) begin
        seen = {assert_mask_i, deassert_mask_i, abnormal_mask_i, raise_ext_flag_i};
        if (verdict_q.size() == 0) begin
          report(1'b1, '0, seen);
        end else begin
          want = verdict_q.pop_front();
          if (want !== seen) report(1'b0, want, seen);
        end
      end
      if (in_valid_i && in_ready_i) begin
        poll_tick(beat_ok_i, ext_abnormal_i, want);
        verdict_q.push_back(want);
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mchw_pkg::*;

  // Generous bound on the whole run; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT = 400000;

  logic                    clk_i;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata   = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic [NUM_CHANNELS-1:0] beat_ok     = '0;
  logic                    ext_abn     = 1'b0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic [NUM_CHANNELS-1:0] assert_mask;
  logic [NUM_CHANNELS-1:0] deassert_mask;
  logic [NUM_CHANNELS-1:0] abnormal_mask;
  logic                    raise_flag;

  int fail_count;
  int pending;
  int cycles = 0;

  // When set, neither side inserts gaps or stalls.
  bit quiet = 1'b0;
  // The external health flag is held between ticks and only flips now and then.
  logic ext_level = 1'b0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  multi_channel_heartbeat_watchdog u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .beat_ok_i        (beat_ok),
    .ext_abnormal_i   (ext_abn),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .assert_mask_o    (assert_mask),
    .deassert_mask_o  (deassert_mask),
    .abnormal_mask_o  (abnormal_mask),
    .raise_ext_flag_o (raise_flag)
  );

  mchw_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .beat_ok_i        (beat_ok),
    .ext_abnormal_i   (ext_abn),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .assert_mask_i    (assert_mask),
    .deassert_mask_i  (deassert_mask),
    .abnormal_mask_i  (abnormal_mask),
    .raise_ext_flag_i (raise_flag),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // The result side stalls at random unless a quiet stretch is running. Only
  // one assignment is made per falling edge, so there is no ordering hazard.
  always @(negedge clk_i) begin
    out_ready <= quiet || ($urandom_range(99) >= 38);
  end

  // Watchdog on the testbench itself: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one poll tick and holds it until the transfer takes place. It is
  // entered and left at a falling edge, and leaves valid high so that a tick
  // following straight on is offered without a dip in valid.
  task automatic send_tick(input logic [NUM_CHANNELS-1:0] beats, input logic ext);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    beat_ok  <= beats;
    ext_abn  <= ext;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Stops offering ticks and waits until every outstanding result has been
  // transferred. The extra edge keeps the lowering of valid in a step of its own.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Writes all three registers on consecutive edges, only once the block has
  // gone idle. Bits above each register's width carry random junk, which the
  // block is expected to ignore.
  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [TICK_W-1:0] tick,
                            input logic [TIMER_W-1:0] limit);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHASSIS_MODE;
    cfg_wdata <= {(CFG_DATA_W-MODE_W)'($urandom_range(63)), mode};
    @(negedge clk_i);
    cfg_index <= REG_TICK_SECONDS;
    cfg_wdata <= {2'($urandom_range(3)), tick};
    @(negedge clk_i);
    cfg_index <= REG_TIMEOUT_SECS;
    cfg_wdata <= limit;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // A run of random ticks. Each channel's heartbeat is ok with the given
  // percentage, and the external flag toggles with the given percentage.
  task automatic random_ticks(input int count, input int ok_pct, input int flip_pct);
    logic [NUM_CHANNELS-1:0] beats;
    for (int n = 0; n < count; n++) begin
      for (int c = 0; c < NUM_CHANNELS; c++) beats[c] = ($urandom_range(99) < ok_pct);
      if ($urandom_range(99) < flip_pct) ext_level = !ext_level;
      send_tick(beats, ext_level);
    end
  endtask

  initial begin
    int ok_pct;
    logic [MODE_W-1:0]  mode;
    logic [TICK_W-1:0]  tick;
    logic [TIMER_W-1:0] limit;

    // Reset is held low and then released at a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Type five chassis: remote SCC is ignored. With a 60 s tick and a 120 s
    // timeout the second miss lands exactly on the timeout and stays normal,
    // and the third one turns the checked channels abnormal.
    set_config(MODE_TYPE5, 6'd60, 8'd120);
    send_tick(4'hF, 1'b0);
    send_tick(4'h0, 1'b0);
    send_tick(4'h0, 1'b0);
    send_tick(4'h0, 1'b0);
    send_tick(4'h0, 1'b0);
    send_tick(4'h1, 1'b0);
    // External flag raised and then dropped: the drop clears every timer after
    // the update, so the channels still missing deassert on the next tick.
    send_tick(4'h0, 1'b1);
    send_tick(4'h0, 1'b1);
    send_tick(4'h0, 1'b0);
    send_tick(4'h0, 1'b0);

    // Type seven chassis with zero registers: a zero tick never grows a timer.
    set_config(MODE_TYPE7, 6'd0, 8'd0);
    send_tick(4'h0, 1'b0);
    send_tick(4'hF, 1'b0);
    // A zero timeout with a nonzero tick trips on the very first miss.
    set_config(MODE_TYPE7, 6'd63, 8'd0);
    send_tick(4'h0, 1'b1);
    send_tick(4'h0, 1'b0);

    // The undefined mode code behaves as an unknown chassis. The largest tick
    // against the largest timeout drives the sum past eight bits.
    set_config(2'd3, 6'd63, 8'd255);
    repeat (5) send_tick(4'h0, 1'b0);
    send_tick(4'hA, 1'b0);

    // Random phases, each under its own register setting. Phases three to
    // five run with no gaps or stalls on either side.
    for (int phase = 0; phase < 16; phase++) begin
      mode = MODE_W'($urandom_range(3));
      case ($urandom_range(5))
        0:       tick = 6'd1;
        1:       tick = 6'd63;
        2:       tick = 6'd60;
        3:       tick = TICK_RESET;
        default: tick = TICK_W'($urandom_range(63));
      endcase
      case ($urandom_range(5))
        0:       limit = 8'd255;
        1:       limit = 8'd1;
        2:       limit = TIMEOUT_RESET;
        default: limit = TIMER_W'($urandom_range(255));
      endcase
      case ($urandom_range(4))
        0:       ok_pct = 0;
        1:       ok_pct = 3;
        2:       ok_pct = 15;
        3:       ok_pct = 50;
        default: ok_pct = 90;
      endcase
      set_config(mode, tick, limit);
      quiet = (phase >= 3 && phase <= 5);
      random_ticks(50, ok_pct, 4);
      // Once in the run the sender holds off until every result is back.
      if (phase == 8) drain_results();
      random_ticks(50, ok_pct, 4);
    end
    quiet = 1'b0;

    drain_results();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[multi_channel_heartbeat_watchdog.f]
rtl/mchw_pkg.sv
rtl/multi_channel_heartbeat_watchdog.sv
test/mchw_checker.sv
test/tb_top.sv
